@@ design/bsfd_pkg.sv @@
// Shared types and constants of the sensor frame decoder.
package bsfd_pkg;

  localparam int unsigned FRAME_LENGTH = 14;
  localparam int unsigned FIELD_FIRST  = 7;
  localparam int unsigned FIELD_COUNT  = 6;

  localparam logic [3:0] POS_HUNT     = 4'd0;
  localparam logic [3:0] POS_FIRST    = 4'd1;
  localparam logic [3:0] POS_CHECKSUM = 4'(FRAME_LENGTH - 1);
  localparam logic [3:0] POS_FIELD_LO = 4'(FIELD_FIRST);
  localparam logic [3:0] POS_FIELD_HI = 4'(FIELD_FIRST + FIELD_COUNT - 1);

  localparam logic [7:0] HEADER_BYTE  = 8'h68;
  localparam logic [3:0] SIGN_NEG     = 4'd1;

  localparam logic       STATUS_OK    = 1'b0;
  localparam logic       STATUS_BAD   = 1'b1;

  localparam int unsigned MAG_W = 18;
  localparam int unsigned VAL_W = 19;

  typedef logic [FIELD_COUNT-1:0][7:0] field_bytes_t;

  typedef struct packed {
    field_bytes_t fields;
    logic         status;
  } frame_t;

endpackage

@@ design/bsfd_front.sv @@
// Front end: header hunt, byte counting, running sum and field capture.
module bsfd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            beat,
  input  logic [7:0]      rx_byte,
  output logic            frame_push,
  output bsfd_pkg::frame_t frame_data
);

  logic [3:0]              pos_r, pos_nxt;
  logic [7:0]              sum_r, sum_nxt;
  bsfd_pkg::field_bytes_t  fields_r;
  logic                    field_we;
  logic [2:0]              field_idx;
  logic [3:0]              field_off;

  assign field_off = pos_r - bsfd_pkg::POS_FIELD_LO;
  assign field_idx = field_off[2:0];
  assign field_we  = beat && (pos_r >= bsfd_pkg::POS_FIELD_LO)
                     && (pos_r <= bsfd_pkg::POS_FIELD_HI);

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    frame_push = 1'b0;
    if (beat) begin
      if (pos_r == bsfd_pkg::POS_HUNT) begin
        if (rx_byte == bsfd_pkg::HEADER_BYTE) begin
          pos_nxt = bsfd_pkg::POS_FIRST;
          sum_nxt = '0;
        end
      end else if (pos_r < bsfd_pkg::POS_CHECKSUM) begin
        sum_nxt = sum_r + rx_byte;
        pos_nxt = pos_r + 4'd1;
      end else begin
        frame_push = 1'b1;
        pos_nxt    = bsfd_pkg::POS_HUNT;
        sum_nxt    = '0;
      end
    end
  end

  assign frame_data.fields = fields_r;
  assign frame_data.status = (rx_byte == sum_r) ? bsfd_pkg::STATUS_OK : bsfd_pkg::STATUS_BAD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= bsfd_pkg::POS_HUNT;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (field_we) begin
      fields_r[field_idx] <= rx_byte;
    end
  end

endmodule

@@ design/bsfd_queue.sv @@
// Frame queue between the front end and the decode stage.
module bsfd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bsfd_pkg::frame_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output bsfd_pkg::frame_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bsfd_pkg::frame_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign valid    = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/bsfd_back.sv @@
// Decode stage: sign-and-BCD conversion into the result register.
module bsfd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  bsfd_pkg::frame_t          q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_take,
  output logic signed [18:0]        angle,
  output logic signed [18:0]        rate,
  output logic                      status
);

  function automatic logic [bsfd_pkg::VAL_W-1:0] decode_bcd3(
    input logic [7:0] lead,
    input logic [7:0] mid,
    input logic [7:0] low
  );
    logic [bsfd_pkg::MAG_W-1:0] mag;
    logic [bsfd_pkg::VAL_W-1:0] wide;
    mag = bsfd_pkg::MAG_W'(lead[3:0]) * bsfd_pkg::MAG_W'(10000)
        + bsfd_pkg::MAG_W'(mid[7:4])  * bsfd_pkg::MAG_W'(1000)
        + bsfd_pkg::MAG_W'(mid[3:0])  * bsfd_pkg::MAG_W'(100)
        + bsfd_pkg::MAG_W'(low[7:4])  * bsfd_pkg::MAG_W'(10)
        + bsfd_pkg::MAG_W'(low[3:0]);
    wide = {1'b0, mag};
    if (lead[7:4] == bsfd_pkg::SIGN_NEG) begin
      wide = ~wide + bsfd_pkg::VAL_W'(1);
    end
    return wide;
  endfunction

  logic                       valid_r, valid_nxt;
  logic [bsfd_pkg::VAL_W-1:0] angle_r, rate_r;
  logic                       status_r;
  logic [bsfd_pkg::VAL_W-1:0] angle_dec, rate_dec;
  logic                       bad;

  assign q_pop     = q_valid && (!valid_r || out_take);
  assign valid_nxt = q_pop || (valid_r && !out_take);
  assign bad       = (q_data.status == bsfd_pkg::STATUS_BAD);
  assign angle_dec = bad ? '0 : decode_bcd3(q_data.fields[3], q_data.fields[4],
                                            q_data.fields[5]);
  assign rate_dec  = bad ? '0 : decode_bcd3(q_data.fields[0], q_data.fields[1],
                                            q_data.fields[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      angle_r  <= angle_dec;
      rate_r   <= rate_dec;
      status_r <= q_data.status;
    end
  end

  assign out_valid = valid_r;
  assign angle     = $signed(angle_r);
  assign rate      = $signed(rate_r);
  assign status    = status_r;

endmodule

@@ design/bcd_sensor_frame_decoder.sv @@
// Top level of the sensor frame decoder.
//
// Input channel: one stream byte per beat on in_rx_byte, taken when in_push
// is high and in_full is low. The front end hunts for header 0x68, counts the
// 13 following bytes, keeps the 8-bit sum of bytes 1 to 12 and captures
// bytes 7 to 12. The checksum byte completes a frame.
// Result channel: one result per completed frame, shown while out_empty is
// low and taken when out_pop is high. frame_status 0 carries the decoded
// angle (bytes 10 to 12) and rate (bytes 7 to 9); frame_status 1 means a
// checksum miss with both values zero, after which hunting resumes.
// Path: a completed frame is written into the queue, then into the result
// register once that is free. Throughput: one byte per cycle while in_full is
// low; the decode stage takes one frame per cycle from the QUEUE_DEPTH
// queue while the result register is free or being taken. When the
// receiver stalls, frames gather in the queue; in_full rises only once the
// queue is full, which needs the result register to be held.
// Synchronous reset returns the front end to hunting and empties the queue
// and the result register.
module bcd_sensor_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [18:0] out_angle_hundredths,
  output logic signed [18:0] out_rate_thousandths,
  output logic               out_frame_status
);

  logic             beat;
  logic             frame_push;
  bsfd_pkg::frame_t frame_data;
  logic             q_full, q_valid, q_pop;
  bsfd_pkg::frame_t q_data;
  logic             out_valid;

  assign in_full   = q_full;
  assign beat      = in_push && !q_full;
  assign out_empty = !out_valid;

  bsfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (beat),
    .rx_byte    (in_rx_byte),
    .frame_push (frame_push),
    .frame_data (frame_data)
  );

  bsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (frame_push),
    .push_data (frame_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  bsfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_take  (out_pop),
    .angle     (out_angle_hundredths),
    .rate      (out_rate_thousandths),
    .status    (out_frame_status)
  );

endmodule

@@ design/bsfd_checker.sv @@
// Port-level checker of the sensor frame decoder and its bind.
module bsfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic [7:0]         in_rx_byte,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [18:0] out_angle_hundredths,
  input logic signed [18:0] out_rate_thousandths,
  input logic               out_frame_status
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input blocked with no result waiting");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_status) |->
      (out_angle_hundredths == 19'sd0 && out_rate_thousandths == 19'sd0))
    else $error("checksum miss carries nonzero values");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_angle_hundredths) && $stable(out_rate_thousandths)
       && $stable(out_frame_status)))
    else $error("stalled result changed");

endmodule

bind bcd_sensor_frame_decoder bsfd_checker u_bsfd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_push              (in_push),
  .in_full              (in_full),
  .in_rx_byte           (in_rx_byte),
  .out_empty            (out_empty),
  .out_pop              (out_pop),
  .out_angle_hundredths (out_angle_hundredths),
  .out_rate_thousandths (out_rate_thousandths),
  .out_frame_status     (out_frame_status)
);

@@ tb/sv/bcd_sensor_frame_decoder_tb.sv @@
// Self-checking testbench for the sensor frame decoder: directed frames, random streams, stalls.
module bcd_sensor_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 1050;
  localparam int unsigned CALM_ITEMS  = 150;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef logic [1:12][7:0] frame_payload_t;

  typedef struct {
    logic signed [bsfd_pkg::VAL_W-1:0] angle;
    logic signed [bsfd_pkg::VAL_W-1:0] rate;
    logic                              status;
  } frame_result_t;

  typedef struct {
    bit             has_junk;
    logic [7:0]     junk;
    frame_payload_t payload;
    bit             corrupt;
    bit             typed;
    frame_result_t  want;
  } frame_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_push = 1'b0;
  logic                              in_full;
  logic [7:0]                        in_rx_byte = 8'h00;
  logic                              out_empty;
  logic                              out_pop = 1'b0;
  logic signed [bsfd_pkg::VAL_W-1:0] out_angle_hundredths;
  logic signed [bsfd_pkg::VAL_W-1:0] out_rate_thousandths;
  logic                              out_frame_status;

  logic [3:0]    frame_pos = bsfd_pkg::POS_HUNT;
  logic [7:0]    frame_sum = 8'h00;
  logic [7:0]    field_store [bsfd_pkg::FIELD_COUNT] = '{default: 8'h00};
  frame_result_t expected_frames [$];
  frame_result_t popped;
  int unsigned   n_sent = 0;
  int unsigned   n_errors = 0;
  int unsigned   cycle_count = 0;
  int unsigned   stall_left = 0;
  bit            calm = 1'b0;

  // byte 1 is the leftmost pair of hex digits
  frame_row_t directed_rows [6] = '{
    '{1'b1, 8'h00, 96'h000000000000_000000_000000, 1'b0, 1'b1,
      '{19'sd0, 19'sd0, bsfd_pkg::STATUS_OK}},
    '{1'b1, 8'hFF, 96'h000000000000_1FFFFF_0FFFFF, 1'b0, 1'b1,
      '{19'sd166665, -19'sd166665, bsfd_pkg::STATUS_OK}},
    '{1'b0, 8'h00, 96'h0123456789AB_109999_012345, 1'b1, 1'b1,
      '{19'sd0, 19'sd0, bsfd_pkg::STATUS_BAD}},
    '{1'b1, 8'h67, 96'h686868686868_2F1234_F09876, 1'b0, 1'b0,
      '{19'sd0, 19'sd0, bsfd_pkg::STATUS_OK}},
    '{1'b0, 8'h00, 96'hFFFFFFFFFFFF_FFFFFF_FFFFFF, 1'b0, 1'b0,
      '{19'sd0, 19'sd0, bsfd_pkg::STATUS_OK}},
    '{1'b1, 8'h69, 96'hA5A5A5A5A5A5_100000_106899, 1'b0, 1'b0,
      '{19'sd0, 19'sd0, bsfd_pkg::STATUS_OK}}
  };

  bcd_sensor_frame_decoder u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_rx_byte           (in_rx_byte),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_angle_hundredths (out_angle_hundredths),
    .out_rate_thousandths (out_rate_thousandths),
    .out_frame_status     (out_frame_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [bsfd_pkg::VAL_W-1:0] bcd_value(input logic [7:0] lead,
                                                                  input logic [7:0] mid,
                                                                  input logic [7:0] low);
    int mag;
    mag = lead[3:0] * 10000 + mid[7:4] * 1000 + mid[3:0] * 100 + low[7:4] * 10 + low[3:0];
    if (lead[7:4] == bsfd_pkg::SIGN_NEG) mag = -mag;
    return bsfd_pkg::VAL_W'(mag);
  endfunction

  function automatic bit decoder_step(input logic [7:0] b, output frame_result_t r);
    bit done;
    done = 1'b0;
    r = '{19'sd0, 19'sd0, bsfd_pkg::STATUS_OK};
    if (frame_pos == bsfd_pkg::POS_HUNT) begin
      if (b == bsfd_pkg::HEADER_BYTE) begin
        frame_sum = 8'h00;
        frame_pos = bsfd_pkg::POS_FIRST;
      end
    end else if (frame_pos != bsfd_pkg::POS_CHECKSUM) begin
      frame_sum = frame_sum + b;
      if (frame_pos >= bsfd_pkg::POS_FIELD_LO && frame_pos <= bsfd_pkg::POS_FIELD_HI)
        field_store[frame_pos - bsfd_pkg::POS_FIELD_LO] = b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      done = 1'b1;
      if (b == frame_sum) begin
        r.angle  = bcd_value(field_store[3], field_store[4], field_store[5]);
        r.rate   = bcd_value(field_store[0], field_store[1], field_store[2]);
        r.status = bsfd_pkg::STATUS_OK;
      end else begin
        r.status = bsfd_pkg::STATUS_BAD;
      end
      frame_pos = bsfd_pkg::POS_HUNT;
      frame_sum = 8'h00;
    end
    return done;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    n_errors++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_t want);
    frame_result_t r;
    calm = (n_sent + CALM_ITEMS >= ITEM_TARGET);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    @(negedge clk);
    while (in_full) @(negedge clk);
    @(posedge clk);
    if (decoder_step(b, r)) expected_frames.push_back(typed ? want : r);
    n_sent++;
  endtask

  task automatic send_frame(input frame_payload_t payload, input bit corrupt, input bit typed,
                            input frame_result_t want);
    logic [7:0] sum;
    sum = 8'h00;
    send_byte(bsfd_pkg::HEADER_BYTE, 1'b0, want);
    for (int i = 1; i <= 12; i++) begin
      sum = sum + payload[i];
      send_byte(payload[i], 1'b0, want);
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum, typed, want);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop    <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left != 0) begin
        out_pop    <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_pop    <= 1'b0;
        stall_left <= $urandom_range(0, 8);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("result with no frame pending, angle", out_angle_hundredths, 0);
      end else begin
        popped = expected_frames.pop_front();
        if (out_angle_hundredths !== popped.angle)
          report_mismatch("angle_hundredths", out_angle_hundredths, popped.angle);
        if (out_rate_thousandths !== popped.rate)
          report_mismatch("rate_thousandths", out_rate_thousandths, popped.rate);
        if (out_frame_status !== popped.status)
          report_mismatch("frame_status", out_frame_status, popped.status);
      end
    end
  end

  initial begin
    frame_payload_t payload;
    frame_result_t  none;
    logic [7:0]     noise;
    none = '{19'sd0, 19'sd0, bsfd_pkg::STATUS_OK};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].has_junk) send_byte(directed_rows[k].junk, 1'b0, none);
      send_frame(directed_rows[k].payload, directed_rows[k].corrupt, directed_rows[k].typed,
                 directed_rows[k].want);
    end

    while (n_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(1, 20)) send_byte(8'($urandom), 1'b0, none);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            noise = 8'($urandom);
            if (noise == bsfd_pkg::HEADER_BYTE) noise = ~noise;
            send_byte(noise, 1'b0, none);
          end
        end
        payload = {$urandom, $urandom, $urandom};
        if ($urandom_range(0, 1) == 0) begin
          payload[7][7:4]  = 4'($urandom_range(0, 1));
          payload[10][7:4] = 4'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 7) == 0) payload[$urandom_range(1, 12)] = bsfd_pkg::HEADER_BYTE;
        send_frame(payload, $urandom_range(0, 4) == 0, 1'b0, none);
      end
    end
    in_push <= 1'b0;

    while (expected_frames.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
